### rtl/bspl_pkg.sv
// Shared types, constants and helpers for the BSP point locator.
`timescale 1ns / 1ps
`default_nettype none
package bspl_pkg;

  localparam int NODE_COUNT_MAX = 4096;
  localparam int NODE_IDX_W     = $clog2(NODE_COUNT_MAX);
  localparam int COUNT_W        = 13;
  localparam int LINK_W         = 16;
  localparam int LEAF_W         = 15;
  localparam int LEAF_FLAG_BIT  = 15;
  localparam int COORD_W        = 32;
  localparam logic [COORD_W-1:0] SIGN32 = 32'h8000_0000;

  localparam logic [LINK_W-1:0] LEAF_FLAG = LINK_W'(1) << LEAF_FLAG_BIT;
  localparam logic [LINK_W-1:0] LINK_LIMIT = LINK_W'(NODE_COUNT_MAX);
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(NODE_COUNT_MAX);

  typedef enum logic [0:0] {
    ACT_WRITE  = 1'b0,
    ACT_LOCATE = 1'b1
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_MUL   = 4'b0100,
    ST_PICK  = 4'b1000
  } walk_state_t;

  typedef struct packed {
    logic [0:0]            action;
    logic [11:0]           node_index;
    logic signed [31:0]    node_x;
    logic signed [31:0]    node_y;
    logic signed [31:0]    node_dx;
    logic signed [31:0]    node_dy;
    logic [15:0]           child_front;
    logic [15:0]           child_back;
    logic signed [31:0]    point_x;
    logic signed [31:0]    point_y;
  } in_item_t;

  typedef struct packed {
    logic [14:0] leaf_index;
    logic        walk_error;
  } out_item_t;

  // one table entry: origin, direction and both links
  typedef struct packed {
    logic [LINK_W-1:0]  back;
    logic [LINK_W-1:0]  front;
    logic [COORD_W-1:0] dy;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] oy;
    logic [COORD_W-1:0] ox;
  } node_ent_t;

  function automatic logic [LEAF_W-1:0] leaf_of(input logic [LINK_W-1:0] link);
    logic [LINK_W-1:0] cleared;
    cleared = link & ~LEAF_FLAG;
    return cleared[LEAF_W-1:0];
  endfunction

endpackage
`default_nettype wire

### rtl/bspl_node_ram.sv
// Node table: single write port, single registered read port.
`timescale 1ns / 1ps
`default_nettype none
module bspl_node_ram
  import bspl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [NODE_IDX_W-1:0] wr_addr,
  input  wire node_ent_t             wr_data,
  input  wire logic                  re,
  input  wire logic [NODE_IDX_W-1:0] rd_addr,
  output node_ent_t                  rd_data
);

  node_ent_t mem [NODE_COUNT_MAX];
  node_ent_t rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

### rtl/bspl_side.sv
// Front/back decision for one node: registered cross products, compare after.
`timescale 1ns / 1ps
`default_nettype none
module bspl_side
  import bspl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire node_ent_t          ent,
  input  wire logic [COORD_W-1:0] px,
  input  wire logic [COORD_W-1:0] py,
  output logic                    back
);

  logic [COORD_W-1:0] ex, ey;
  logic signed [47:0] prod_l, prod_r;
  logic               dy_pos, dy_neg, dx_pos, dx_neg;
  logic               fast, fast_back;

  logic               fast_r, fast_back_r;
  logic signed [31:0] lft_r, rgt_r;

  always_comb begin
    ex     = px - ent.ox;
    ey     = py - ent.oy;
    dy_neg = ent.dy[COORD_W-1];
    dx_neg = ent.dx[COORD_W-1];
    dy_pos = !dy_neg && (ent.dy != '0);
    dx_pos = !dx_neg && (ent.dx != '0);
    // integer part of the direction times the offset; upper bits are the floor
    prod_l = $signed(ent.dy[31:16]) * $signed(ex);
    prod_r = $signed(ey) * $signed(ent.dx[31:16]);
    fast      = 1'b1;
    fast_back = 1'b0;
    if (ent.dx == '0) begin
      if ($signed(px) <= $signed(ent.ox)) fast_back = dy_pos;
      else                                fast_back = dy_neg;
    end else if (ent.dy == '0) begin
      if ($signed(py) <= $signed(ent.oy)) fast_back = dx_neg;
      else                                fast_back = dx_pos;
    end else if (((ent.dy ^ ent.dx ^ ex ^ ey) & SIGN32) != '0) begin
      fast_back = ((ent.dy ^ ex) & SIGN32) != '0;
    end else begin
      fast = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fast_r      <= fast;
      fast_back_r <= fast_back;
      lft_r       <= prod_l[47:16];
      rgt_r       <= prod_r[47:16];
    end
  end

  assign back = fast_r ? fast_back_r : !(rgt_r < lft_r);

endmodule
`default_nettype wire

### rtl/bsp_point_locate_top.sv
// BSP point locator: node table load, tree walk sequencer and result register.
//
//   channel | ports                         | handshake
//   --------+-------------------------------+------------------------------
//   input   | start, busy, in_item          | taken when start & !busy
//   result  | out_strobe, out_item          | one-cycle strobe, no back-pressure
//   config  | cfg_valid, cfg_ready, cfg_... | written when valid & ready
//
// A node write leaves busy low. A locate holds busy through the FETCH (table read),
// MUL (cross products) and PICK (compare and link select) states of every node
// visited; the result strobe follows the last of them. An empty tree gives its
// word in the cycle after the locate, with busy never raised. Reset clears the
// node count and the sequencer; the node table is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module bsp_point_locate_top
  import bspl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire in_item_t           in_item,
  output logic                    out_strobe,
  output out_item_t               out_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [COUNT_W-1:0] cfg_node_count
);

  walk_state_t         state_r, state_nxt;
  logic [COUNT_W-1:0]  node_count_r;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [COUNT_W-1:0]  steps_r, steps_nxt;
  logic [LINK_W-1:0]   node_r, node_nxt;
  logic [COORD_W-1:0]  px_r, py_r, px_nxt, py_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  out_item_t           out_item_r, out_item_nxt;

  logic                accept;
  logic [COUNT_W-1:0]  count_clamped;
  logic [LINK_W-1:0]   root;
  logic [LINK_W-1:0]   link;
  logic                we;
  node_ent_t           wr_ent;
  node_ent_t           rd_ent;
  logic                back;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    wr_ent.ox    = in_item.node_x;
    wr_ent.oy    = in_item.node_y;
    wr_ent.dx    = in_item.node_dx;
    wr_ent.dy    = in_item.node_dy;
    wr_ent.front = in_item.child_front;
    wr_ent.back  = in_item.child_back;
  end

  // the index field is exactly as wide as the table, so every write lands
  assign we = accept && (in_item.action == ACT_WRITE);

  bspl_node_ram u_ram (
    .clk     (clk),
    .we      (we),
    .wr_addr (in_item.node_index),
    .wr_data (wr_ent),
    .re      (state_r == ST_FETCH),
    .rd_addr (node_r[NODE_IDX_W-1:0]),
    .rd_data (rd_ent)
  );

  bspl_side u_side (
    .clk  (clk),
    .en   (state_r == ST_MUL),
    .ent  (rd_ent),
    .px   (px_r),
    .py   (py_r),
    .back (back)
  );

  assign count_clamped = (node_count_r > COUNT_LIMIT) ? COUNT_LIMIT : node_count_r;
  assign root          = LINK_W'(count_clamped - COUNT_W'(1));
  assign link          = back ? rd_ent.back : rd_ent.front;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    steps_nxt      = steps_r;
    node_nxt       = node_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_item.action == ACT_LOCATE)) begin
          px_nxt    = in_item.point_x;
          py_nxt    = in_item.point_y;
          count_nxt = count_clamped;
          steps_nxt = '0;
          node_nxt  = root;
          if (count_clamped == '0) begin
            out_strobe_nxt          = 1'b1;
            out_item_nxt.leaf_index = '0;
            out_item_nxt.walk_error = 1'b0;
          end else if ((root & LEAF_FLAG) != '0) begin
            out_strobe_nxt          = 1'b1;
            out_item_nxt.leaf_index = leaf_of(root);
            out_item_nxt.walk_error = 1'b0;
          end else if (root >= LINK_LIMIT) begin
            out_strobe_nxt          = 1'b1;
            out_item_nxt.leaf_index = '0;
            out_item_nxt.walk_error = 1'b1;
          end else begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_FETCH: state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_PICK;
      ST_PICK: begin
        steps_nxt = steps_r + COUNT_W'(1);
        node_nxt  = link;
        if ((link & LEAF_FLAG) != '0) begin
          out_strobe_nxt          = 1'b1;
          out_item_nxt.leaf_index = leaf_of(link);
          out_item_nxt.walk_error = 1'b0;
          state_nxt               = ST_IDLE;
        end else if ((link >= LINK_LIMIT) || (steps_nxt >= count_r)) begin
          out_strobe_nxt          = 1'b1;
          out_item_nxt.leaf_index = '0;
          out_item_nxt.walk_error = 1'b1;
          state_nxt               = ST_IDLE;
        end else begin
          state_nxt = ST_FETCH;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      node_count_r <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        node_count_r <= cfg_node_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    count_r    <= count_nxt;
    steps_r    <= steps_nxt;
    node_r     <= node_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule
`default_nettype wire

### tb/bsp_point_locate_checker.sv
// Checker for the BSP point locator: keeps its own node table and walk, compares each result word.
`timescale 1ns / 1ps
module bsp_point_locate_checker
  import bspl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  in_item_t           in_item,
  input  logic               out_strobe,
  input  out_item_t          out_item,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_node_count,
  output int                 mismatches,
  output int                 pending
);

  node_ent_t          node_tbl [NODE_COUNT_MAX];
  logic [COUNT_W-1:0] node_count;
  out_item_t          expected_leaves [$];
  out_item_t          oldest;

  // 1 for the back side of the partition line of node idx
  function automatic logic on_back_side(input logic signed [31:0] px,
                                        input logic signed [31:0] py, input int idx);
    logic signed [31:0] ox, oy, ux, uy, ex, ey;
    longint lft, rgt;
    ox = node_tbl[idx].ox;
    oy = node_tbl[idx].oy;
    ux = node_tbl[idx].dx;
    uy = node_tbl[idx].dy;
    if (ux == 0) begin
      return (px <= ox) ? (uy > 0) : (uy < 0);
    end
    if (uy == 0) begin
      return (py <= oy) ? (ux < 0) : (ux > 0);
    end
    ex = px - ox;
    ey = py - oy;
    // signs disagree: the answer follows from the signs alone
    if (uy[31] ^ ux[31] ^ ex[31] ^ ey[31]) begin
      return uy[31] ^ ex[31];
    end
    lft = ((longint'(uy) >>> 16) * longint'(ex)) >>> 16;
    rgt = (longint'(ey) * (longint'(ux) >>> 16)) >>> 16;
    return !(rgt < lft);
  endfunction

  function automatic out_item_t locate_leaf(input logic signed [31:0] px,
                                            input logic signed [31:0] py);
    int count, n, steps;
    logic [LINK_W-1:0] link;
    out_item_t res;
    res = '0;
    count = (node_count > COUNT_LIMIT) ? NODE_COUNT_MAX : int'(node_count);
    if (count == 0) begin
      return res;
    end
    n = count - 1;
    if (n[LEAF_FLAG_BIT]) begin
      res.leaf_index = n[LEAF_W-1:0];
      return res;
    end
    steps = 0;
    while (steps < count && n < NODE_COUNT_MAX) begin
      link = on_back_side(px, py, n) ? node_tbl[n].back : node_tbl[n].front;
      if (link[LEAF_FLAG_BIT]) begin
        res.leaf_index = link[LEAF_W-1:0];
        return res;
      end
      n = int'(link);
      steps++;
    end
    res.walk_error = 1'b1;
    return res;
  endfunction

  task automatic note_mismatch(input string what, input out_item_t exp_w, input out_item_t got_w);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected leaf %0d err %0b, got leaf %0d err %0b", $realtime, what,
               exp_w.leaf_index, exp_w.walk_error, got_w.leaf_index, got_w.walk_error);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      node_count = '0;
      expected_leaves.delete();
      mismatches = 0;
    end else begin
      if (out_strobe) begin
        if (expected_leaves.size() == 0) begin
          note_mismatch("result word with none expected", '0, out_item);
        end else begin
          oldest = expected_leaves.pop_front();
          if (oldest.leaf_index !== out_item.leaf_index ||
              oldest.walk_error !== out_item.walk_error) begin
            note_mismatch("result word wrong", oldest, out_item);
          end
        end
      end
      if (start && !busy) begin
        if (in_item.action == ACT_LOCATE) begin
          expected_leaves.push_back(locate_leaf(in_item.point_x, in_item.point_y));
        end else begin
          node_tbl[in_item.node_index].ox    = in_item.node_x;
          node_tbl[in_item.node_index].oy    = in_item.node_y;
          node_tbl[in_item.node_index].dx    = in_item.node_dx;
          node_tbl[in_item.node_index].dy    = in_item.node_dy;
          node_tbl[in_item.node_index].front = in_item.child_front;
          node_tbl[in_item.node_index].back  = in_item.child_back;
        end
      end
      if (cfg_valid && cfg_ready) begin
        node_count = cfg_node_count;
      end
    end
    pending = expected_leaves.size();
  end

endmodule

### tb/bsp_point_locate_top_test.sv
// Testbench top for the BSP point locator: clock, reset, tree building and locate stimulus, verdict.
`timescale 1ns / 1ps
module bsp_point_locate_top_test;
  import bspl_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  in_item_t           in_item;
  logic               out_strobe;
  out_item_t          out_item;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_node_count;
  int                 mismatches;
  int                 pending;

  // tree bookkeeping so that no walk ever reads an unwritten entry
  bit node_written [NODE_COUNT_MAX];
  int written_nodes [$];
  int eff_n, tree_k, root_idx;
  bit allow_any;
  int idle_pct;
  bit quiet;
  int words_sent;

  bsp_point_locate_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_item        (in_item),
    .out_strobe     (out_strobe),
    .out_item       (out_item),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_node_count (cfg_node_count)
  );

  bsp_point_locate_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_item        (in_item),
    .out_strobe     (out_strobe),
    .out_item       (out_item),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_node_count (cfg_node_count),
    .mismatches     (mismatches),
    .pending        (pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [31:0] rand_coord(input int zero_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < zero_pct) begin
      return '0;
    end
    if (r < zero_pct + 10) begin
      return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    // within +-8.0, where the cross products decide
    if (r < zero_pct + 55) begin
      return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
    end
    return $urandom;
  endfunction

  // limit: tree links go below this index, so well-formed walks end
  function automatic logic [LINK_W-1:0] pick_link(input int limit, input bit any);
    int r;
    r = $urandom_range(0, 99);
    if (r < 30 || (limit == 0 && r >= 46)) begin
      return LEAF_FLAG | LINK_W'($urandom_range(0, 32'h7FFF));
    end
    if (r < 40 && any) begin
      return LINK_W'(written_nodes[$urandom_range(0, written_nodes.size() - 1)]);
    end
    if (r < 46) begin
      return LINK_W'($urandom_range(NODE_COUNT_MAX, 32'h7FFF));
    end
    if (r < 70) begin
      return LINK_W'(limit - 1);
    end
    return LINK_W'($urandom_range(0, limit - 1));
  endfunction

  function automatic in_item_t node_word(input int idx, input logic [31:0] x, input logic [31:0] y,
                                         input logic [31:0] dx, input logic [31:0] dy,
                                         input logic [LINK_W-1:0] front,
                                         input logic [LINK_W-1:0] back);
    in_item_t w;
    w.action      = ACT_WRITE;
    w.node_index  = 12'(idx);
    w.node_x      = x;
    w.node_y      = y;
    w.node_dx     = dx;
    w.node_dy     = dy;
    w.child_front = front;
    w.child_back  = back;
    w.point_x     = $urandom;
    w.point_y     = $urandom;
    return w;
  endfunction

  function automatic in_item_t locate_word(input logic [31:0] px, input logic [31:0] py);
    in_item_t w;
    w = node_word($urandom_range(0, NODE_COUNT_MAX - 1), $urandom, $urandom, $urandom, $urandom,
                  16'($urandom), 16'($urandom));
    w.action  = ACT_LOCATE;
    w.point_x = px;
    w.point_y = py;
    return w;
  endfunction

  function automatic in_item_t tree_word(input int idx);
    int limit;
    limit = (idx == root_idx && idx >= tree_k) ? tree_k : idx;
    return node_word(idx, rand_coord(5), rand_coord(5), rand_coord(15), rand_coord(15),
                     pick_link(limit, allow_any), pick_link(limit, allow_any));
  endfunction

  task automatic send_word(input in_item_t w);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 13);
    end
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    in_item <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (w.action == ACT_WRITE && !node_written[w.node_index]) begin
      node_written[w.node_index] = 1'b1;
      written_nodes.push_back(int'(w.node_index));
    end
    words_sent++;
  endtask

  task automatic wait_idle();
    do begin
      @(negedge clk);
      start <= 1'b0;
    end while (pending != 0 || busy);
  endtask

  task automatic set_count(input int v);
    wait_idle();
    // a node write leaves no result word behind; give it time to land
    repeat (4) @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_node_count <= COUNT_W'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int cnt, ops, r;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_item        = '0;
    cfg_valid      = 1'b0;
    cfg_node_count = '0;
    quiet          = 1'b0;
    idle_pct       = 20;
    words_sent     = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty tree straight out of reset
    send_word(locate_word(32'h7FFF_FFFF, 32'h8000_0000));
    send_word(node_word(NODE_COUNT_MAX - 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 16'hFFFF, 16'h8000));
    // vertical line
    send_word(node_word(0, 0, 0, 0, 32'h0001_0000, 16'h8001, 16'h8002));
    set_count(1);
    send_word(locate_word(32'hFFFF_FFFF, 0));
    send_word(locate_word(32'h0000_0001, 0));
    send_word(locate_word(0, 32'h1234_5678));
    // horizontal line
    send_word(node_word(0, 0, 0, 32'hFFFF_0000, 0, 16'h8003, 16'h8004));
    send_word(locate_word(0, 0));
    send_word(locate_word(0, 32'h0000_0005));
    // general line: cross products and the sign shortcut
    send_word(node_word(0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0002_0000,
                        16'h8005, 16'h8006));
    send_word(locate_word(32'h0003_0000, 32'h0001_0000));
    send_word(locate_word(32'h8000_0000, 32'h7FFF_FFFF));
    send_word(locate_word(32'h0005_0000, 32'h0006_0000));
    // degenerate direction
    send_word(node_word(0, 5, 5, 0, 0, 16'h8007, 16'h8008));
    send_word(locate_word(0, 0));
    // two levels, back link beyond the table
    send_word(node_word(1, 0, 0, 32'h0001_0000, 32'h0001_0000, 16'h0000, 16'h1000));
    set_count(2);
    send_word(locate_word(32'h0002_0000, 32'h0001_0000));
    send_word(locate_word(32'h0001_0000, 32'h0002_0000));
    // self loop: walk runs out of steps
    send_word(node_word(1, 0, 0, 0, 0, 16'h0001, 16'h0001));
    send_word(locate_word(0, 0));
    // oversized count clamps the root to the last entry
    set_count(8191);
    send_word(locate_word(0, 0));
    send_word(node_word(NODE_COUNT_MAX - 1, 0, 0, 0, 0, 16'h0001, 16'h0001));
    send_word(locate_word(0, 0));
    send_word(node_word(NODE_COUNT_MAX - 1, 0, 0, 0, 0, 16'h7FFF, 16'h7FFF));
    set_count(NODE_COUNT_MAX);
    send_word(locate_word(32'h8000_0000, 0));

    while (words_sent < 1475) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        cnt = 0;
      end else if (r < 20) begin
        case ($urandom_range(0, 4))
          0: cnt = NODE_COUNT_MAX;
          1: cnt = 8191;
          2: cnt = NODE_COUNT_MAX - 1;
          3: cnt = $urandom_range(NODE_COUNT_MAX + 1, 8191);
          default: cnt = $urandom_range(65, NODE_COUNT_MAX - 2);
        endcase
      end else begin
        cnt = $urandom_range(1, 40);
      end
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 10;
        default: idle_pct = 35;
      endcase
      set_count(cnt);
      eff_n     = (cnt > NODE_COUNT_MAX) ? NODE_COUNT_MAX : cnt;
      allow_any = (eff_n <= 64);
      if (eff_n > 0) begin
        tree_k   = $urandom_range(1, 24);
        tree_k   = (tree_k > eff_n) ? eff_n : tree_k;
        root_idx = eff_n - 1;
        for (int i = 0; i < tree_k; i++) begin
          send_word(tree_word(i));
        end
        if (root_idx >= tree_k) begin
          send_word(tree_word(root_idx));
        end
      end
      ops = $urandom_range(15, 45);
      repeat (ops) begin
        quiet = (words_sent > 1300);
        r = $urandom_range(0, 99);
        if (eff_n > 0 && r < 8) begin
          send_word(tree_word(($urandom_range(0, 3) == 0) ? root_idx
                                                          : $urandom_range(0, tree_k - 1)));
        end else if (r < 12) begin
          send_word(node_word($urandom_range(0, NODE_COUNT_MAX - 1), rand_coord(5), rand_coord(5),
                              rand_coord(15), rand_coord(15), pick_link(0, allow_any),
                              pick_link(0, allow_any)));
        end else begin
          send_word(locate_word(rand_coord(5), rand_coord(5)));
        end
      end
    end

    wait_idle();
    repeat (64) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
